// File: rtl/sorted_timestamp_buffer_macros.svh
// Assertion macros for the sorted timestamp buffer.
// Used by the top level only; no other dependencies.
`ifndef SORTED_TIMESTAMP_BUFFER_MACROS_SVH
`define SORTED_TIMESTAMP_BUFFER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define STB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stb assertion failed");
// next-cycle implication
`define STB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stb assertion failed");
`else
`define STB_ASSERT_NOW(lbl, ante, cons)
`define STB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/stb_pkg.sv
// Shared types and constants for the sorted timestamp buffer.
// No dependencies.
package stb_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int STAMP_W      = 64;
  localparam int SAMPLE_W     = 64;
  localparam int POS_W        = 8;
  localparam int COUNT_W      = 9;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  // per-cell strobes: capture compare result, commit shift/insert
  typedef struct packed {
    logic capture;
    logic write;
  } cell_ctrl_t;

endpackage

// File: rtl/stb_cell.sv
// One storage cell of the sorted chain: holds a pair and its compare flag.
// Depends on stb_pkg.
module stb_cell
  import stb_pkg::*;
(
  input  logic                clk,
  input  cell_ctrl_t          ctrl,
  input  logic                occupied,
  input  logic [STAMP_W-1:0]  cmp_stamp,
  input  logic [STAMP_W-1:0]  new_stamp,
  input  logic [SAMPLE_W-1:0] new_sample,
  input  logic [STAMP_W-1:0]  left_stamp,
  input  logic [SAMPLE_W-1:0] left_sample,
  input  logic                left_lt,
  output logic [STAMP_W-1:0]  stamp,
  output logic [SAMPLE_W-1:0] sample,
  output logic                lt,
  output logic                hit
);

  logic [STAMP_W-1:0]  stamp_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                lt_r;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      lt_r <= occupied && (stamp_r < cmp_stamp);
    end
    if (ctrl.write) begin
      if (!left_lt) begin
        // above the insert point: take the left neighbor
        stamp_r  <= left_stamp;
        sample_r <= left_sample;
      end else if (!lt_r) begin
        // the insert point itself
        stamp_r  <= new_stamp;
        sample_r <= new_sample;
      end
    end
  end

  assign stamp  = stamp_r;
  assign sample = sample_r;
  assign lt     = lt_r;
  assign hit    = left_lt && !lt_r;

endmodule

// File: rtl/stb_select.sv
// One-hot AND-OR selector across the cell row.
// Depends on stb_pkg for its parameter defaults; generic in width and depth.
module stb_select
  import stb_pkg::*;
#(
  parameter int N = CAPACITY_DEF,
  parameter int W = STAMP_W
) (
  input  logic [W-1:0] data [N],
  input  logic [N-1:0] sel,
  output logic [W-1:0] q
);

  always_comb begin
    q = '0;
    for (int i = 0; i < N; i++) begin
      q = q | (data[i] & {W{sel[i]}});
    end
  end

endmodule

// File: rtl/sorted_timestamp_buffer.sv
// Sorted timestamp buffer: top level with the cell row and its sequencer.
// Depends on stb_pkg, stb_cell, stb_select and sorted_timestamp_buffer_macros.svh.
//
// Usage: an item is taken when start is high and busy is low. In the
// accept cycle every cell compares its stored timestamp against in_stamp
// at once; in the next cycle (busy high) the row shifts everything at and
// above the insert point up by one cell and writes the new pair, or the
// addressed cell is picked for a read. The result appears on the out_
// ports for exactly one cycle with out_valid high, the cycle right after
// the busy cycle; a new item can be taken in that same cycle. The receiver
// cannot stall: results must be taken when out_valid is high. Equal
// timestamps keep arrival order reversed: a new pair goes before stored
// equals. An insert into a full buffer is dropped with status 1; a read at
// or beyond the entry count returns status 2 with zero data. The cell row
// needs no clearing after reset: only cells below the count are read.
`include "sorted_timestamp_buffer_macros.svh"

module sorted_timestamp_buffer
  import stb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_opcode,
  input  logic [STAMP_W-1:0]  in_stamp,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic [POS_W-1:0]    in_position,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [STAMP_W-1:0]  out_entry_stamp,
  output logic [SAMPLE_W-1:0] out_entry_sample,
  output logic [POS_W-1:0]    out_slot,
  output logic [COUNT_W-1:0]  out_entry_count
);

  localparam int FW = $clog2(CAPACITY + 1);        // fill count width
  localparam int MW = (FW > POS_W) ? FW : POS_W;   // position compare width
  localparam int DW = STAMP_W + SAMPLE_W;

  // sequencer and item registers
  state_t              state_r, state_nxt;
  logic                op_r;
  logic [STAMP_W-1:0]  stamp_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [POS_W-1:0]    pos_r;
  logic [FW-1:0]       fill_r, fill_nxt;

  // result word
  logic                out_valid_r;
  status_t             status_r, status_nxt;
  logic [STAMP_W-1:0]  ostamp_r, ostamp_nxt;
  logic [SAMPLE_W-1:0] osample_r, osample_nxt;
  logic [POS_W-1:0]    oslot_r, oslot_nxt;

  logic                accept;
  logic                full;
  logic                read_ok;
  cell_ctrl_t          ctrl;

  // cell row wiring
  logic [STAMP_W-1:0]  c_stamp  [CAPACITY];
  logic [SAMPLE_W-1:0] c_sample [CAPACITY];
  logic [DW-1:0]       c_data   [CAPACITY];
  logic [POS_W-1:0]    c_index  [CAPACITY];
  logic [CAPACITY-1:0] c_lt;
  logic [CAPACITY-1:0] c_hit;
  logic [CAPACITY-1:0] c_match;
  logic [DW-1:0]       rd_data;
  logic [POS_W-1:0]    ins_slot;

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r == S_EVAL);
  assign full    = (fill_r == FW'(CAPACITY));
  assign read_ok = (MW'(pos_r) < MW'(fill_r));

  assign ctrl.capture = accept;
  assign ctrl.write   = (state_r == S_EVAL) && (op_r == OP_INSERT) && !full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [STAMP_W-1:0]  left_stamp;
    logic [SAMPLE_W-1:0] left_sample;
    logic                left_lt;

    if (i == 0) begin : g_head
      // nothing to the left: the head never shifts in
      assign left_stamp  = '0;
      assign left_sample = '0;
      assign left_lt     = 1'b1;
    end else begin : g_link
      assign left_stamp  = c_stamp[i-1];
      assign left_sample = c_sample[i-1];
      assign left_lt     = c_lt[i-1];
    end

    stb_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (FW'(i) < fill_r),
      .cmp_stamp   (in_stamp),
      .new_stamp   (stamp_r),
      .new_sample  (sample_r),
      .left_stamp  (left_stamp),
      .left_sample (left_sample),
      .left_lt     (left_lt),
      .stamp       (c_stamp[i]),
      .sample      (c_sample[i]),
      .lt          (c_lt[i]),
      .hit         (c_hit[i])
    );

    assign c_data[i]  = {c_stamp[i], c_sample[i]};
    assign c_index[i] = POS_W'(i);
    assign c_match[i] = (MW'(pos_r) == MW'(i));
  end

  // read pick
  stb_select #(.N(CAPACITY), .W(DW)) u_read_sel (
    .data (c_data),
    .sel  (c_match),
    .q    (rd_data)
  );

  // insert point: one-hot at the first cell not below the new stamp
  stb_select #(.N(CAPACITY), .W(POS_W)) u_slot_enc (
    .data (c_index),
    .sel  (c_hit),
    .q    (ins_slot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= (state_r == S_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_opcode;
      stamp_r  <= in_stamp;
      sample_r <= in_sample;
      pos_r    <= in_position;
    end
    if (state_r == S_EVAL) begin
      status_r  <= status_nxt;
      ostamp_r  <= ostamp_nxt;
      osample_r <= osample_nxt;
      oslot_r   <= oslot_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    status_nxt  = ST_OK;
    ostamp_nxt  = '0;
    osample_nxt = '0;
    oslot_nxt   = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        if (op_r == OP_INSERT) begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            oslot_nxt = ins_slot;
            fill_nxt  = fill_r + FW'(1);
          end
        end else begin
          if (read_ok) begin
            ostamp_nxt  = rd_data[DW-1:SAMPLE_W];
            osample_nxt = rd_data[SAMPLE_W-1:0];
          end else begin
            status_nxt = ST_RANGE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_entry_stamp  = ostamp_r;
  assign out_entry_sample = osample_r;
  assign out_slot         = oslot_r;
  assign out_entry_count  = COUNT_W'(fill_r);

  // every accepted word occupies exactly one busy cycle, then one result
  `STB_ASSERT_NEXT(a_accept_busy, accept, busy)
  `STB_ASSERT_NEXT(a_busy_result, busy, out_valid && !busy)
  // the row never claims more entries than it has cells
  `STB_ASSERT_NOW(a_fill_bound, 1'b1, fill_r <= FW'(CAPACITY))
  // a dropped insert leaves the count at capacity
  `STB_ASSERT_NOW(a_full_count, out_valid && (status_r == ST_FULL), fill_r == FW'(CAPACITY))

endmodule
